[rtl/mlptw_pkg.sv]
package mlptw_pkg;

   // default geometry of the walker
   localparam int PAGE_OFFSET_BITS_DEF = 12;
   localparam int LEVEL_COUNT_DEF      = 4;
   localparam int FRAME_COUNT_DEF      = 16;

   // fixed field widths
   localparam int VA_W          = 48;
   localparam int PA_W          = 16;
   localparam int REQ_TDATA_W   = 56;
   localparam int RSP_TDATA_W   = 24;
   localparam int ENTRY_IDX_SUB = 3;

   // request operation codes
   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_ALLOCATE  = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic root_take;
      logic walk_begin;
      logic walk_step;
      logic entry_alloc;
      logic res_load;
      logic res_mapped;
      logic res_oof;
      logic out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic root_zero;
      logic frames_left;
      logic req_alloc;
      logic op_alloc;
      logic entry_valid;
      logic last_level;
   } status_type;

endpackage

[rtl/mlptw_ram.sv]
module mlptw_ram
   import mlptw_pkg::*;
#(
   parameter int WIDTH = PAGE_OFFSET_BITS_DEF,
   parameter int DEPTH = FRAME_COUNT_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mlptw_dp.sv]
module mlptw_dp
   import mlptw_pkg::*;
#(
   parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF,
   parameter int LEVEL_COUNT      = LEVEL_COUNT_DEF,
   parameter int FRAME_COUNT      = FRAME_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W  = PAGE_OFFSET_BITS - ENTRY_IDX_SUB;
   localparam int FB     = $clog2(FRAME_COUNT);
   localparam int NFW    = FB + 1;
   localparam int EW     = FB + 1;
   localparam int AW     = FB + IDX_W;
   localparam int DEPTH  = FRAME_COUNT * (2 ** IDX_W);
   localparam int LW     = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
   localparam int LW1    = LW + 1;
   localparam int SHIFT0 = PAGE_OFFSET_BITS + (LEVEL_COUNT - 1) * IDX_W;

   logic [VA_W-1:0]  va_ff;
   logic             op_ff;
   logic [FB-1:0]    frame_ff;
   logic [FB-1:0]    root_ff;
   logic [NFW-1:0]   next_free_ff;
   logic [LW-1:0]    level_ff;
   logic [AW-1:0]    clr_ff;
   logic             mapped_ff;
   logic             oof_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;

   logic [VA_W-1:0]  req_va;
   logic [IDX_W-1:0] idx_va [LEVEL_COUNT];
   logic [IDX_W-1:0] idx_cur;
   logic [IDX_W-1:0] idx_next;
   logic [IDX_W-1:0] idx_req0;
   logic [FB-1:0]    root_eff;
   logic [FB-1:0]    rd_frame;
   logic [FB-1:0]    frame_nxt;
   logic [EW-1:0]    rd_data;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [EW-1:0]    wr_data;
   logic [AW-1:0]    rd_addr;
   logic [PA_W+FB+PAGE_OFFSET_BITS-1:0] pa_wide;
   logic [PA_W-1:0]  pa_out;

   assign req_va = req_tdata[VA_W:1];

   // per-level index, most significant level first; far shifts read as zero
   for (genvar l = 0; l < LEVEL_COUNT; l++) begin : g_idx
      localparam int SH = PAGE_OFFSET_BITS + (LEVEL_COUNT - 1 - l) * IDX_W;
      assign idx_va[l] = IDX_W'(va_ff >> SH);
   end

   assign idx_req0 = IDX_W'(req_va >> SHIFT0);

   // index of the current and the following level
   always_comb begin
      idx_cur  = '0;
      idx_next = '0;
      for (int l = 0; l < LEVEL_COUNT; l++) begin
         if (level_ff == LW'(l)) begin
            idx_cur = idx_va[l];
         end
         if (({1'b0, level_ff} + 1'b1) == LW1'(l)) begin
            idx_next = idx_va[l];
         end
      end
   end

   // frame selection
   assign rd_frame  = rd_data[FB:1];
   assign root_eff  = (root_ff == '0) ? next_free_ff[FB-1:0] : root_ff;
   assign frame_nxt = rd_data[0] ? rd_frame : next_free_ff[FB-1:0];

   // store ports: clearing pass or new entry on write, walk on read
   assign wr_en   = cmd.clear_step | cmd.entry_alloc;
   assign wr_addr = cmd.clear_step ? clr_ff : {frame_ff, idx_cur};
   assign wr_data = cmd.clear_step ? '0 : {next_free_ff[FB-1:0], 1'b1};
   assign rd_addr = cmd.accept ? {root_eff, idx_req0} : {frame_nxt, idx_next};

   mlptw_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // status back to the controller
   assign status.clear_last  = (clr_ff == AW'(DEPTH - 1));
   assign status.root_zero   = (root_ff == '0);
   assign status.frames_left = (next_free_ff < NFW'(FRAME_COUNT));
   assign status.req_alloc   = (req_tdata[0] == OP_ALLOCATE);
   assign status.op_alloc    = (op_ff == OP_ALLOCATE);
   assign status.entry_valid = rd_data[0];
   assign status.last_level  = (level_ff == LW'(LEVEL_COUNT - 1));

   // control state: clearing sweep, root and bump allocator
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         root_ff      <= '0;
         next_free_ff <= NFW'(1);
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.root_take) begin
            root_ff <= next_free_ff[FB-1:0];
         end
         if (cmd.root_take || cmd.entry_alloc) begin
            next_free_ff <= next_free_ff + 1'b1;
         end
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         va_ff <= req_va;
         op_ff <= req_tdata[0];
      end
      if (cmd.walk_begin) begin
         frame_ff <= root_eff;
         level_ff <= '0;
      end else if (cmd.walk_step) begin
         frame_ff <= frame_nxt;
         level_ff <= level_ff + 1'b1;
      end
      if (cmd.res_load) begin
         mapped_ff <= cmd.res_mapped;
         oof_ff    <= cmd.res_oof;
      end
   end

   // physical address from the leaf frame and the page offset
   assign pa_wide = {PA_W'(0), frame_ff, va_ff[PAGE_OFFSET_BITS-1:0]};
   assign pa_out  = mapped_ff ? pa_wide[PA_W-1:0] : '0;

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_tdata_ff <= {(RSP_TDATA_W - PA_W - 2)'(0), oof_ff, mapped_ff, pa_out};
      end
   end

   assign rsp_tdata = rsp_tdata_ff;

   // frames along a path are handed out in increasing order
   a_path_rising: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_step && rd_data[0]) |-> (rd_frame > frame_ff))
      else $error("walk reached a frame not newer than its table");

   // the bump counter stops at the frame count
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NFW'(FRAME_COUNT))
      else $error("free frame counter ran past the store");

   // an installed root was taken from the allocator
   a_root_taken: assert property (@(posedge clock) disable iff (reset)
      (root_ff != '0) |-> ({1'b0, root_ff} < next_free_ff))
      else $error("root frame not below the free frame counter");

endmodule

[rtl/mlptw_ctrl.sv]
module mlptw_ctrl
   import mlptw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_tvalid_ff;
   logic      rsp_tvalid_in;
   logic      slot_free;
   logic      accept;

   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && slot_free);
   assign accept     = req_tvalid && req_tready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE, ST_DONE: begin
            if (state_ff == ST_DONE) begin
               cmd.out_load = slot_free;
               if (slot_free) begin
                  state_in = ST_IDLE;
               end
            end
            if (accept) begin
               cmd.accept = 1'b1;
               if (!status.root_zero) begin
                  cmd.walk_begin = 1'b1;
                  state_in       = ST_WALK;
               end else if (!status.req_alloc) begin
                  cmd.res_load = 1'b1;
                  state_in     = ST_DONE;
               end else if (!status.frames_left) begin
                  cmd.res_load = 1'b1;
                  cmd.res_oof  = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  cmd.root_take  = 1'b1;
                  cmd.walk_begin = 1'b1;
                  state_in       = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.entry_valid) begin
               if (status.last_level) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_mapped = 1'b1;
                  state_in       = ST_DONE;
               end
            end else if (!status.op_alloc) begin
               cmd.res_load = 1'b1;
               state_in     = ST_DONE;
            end else if (!status.frames_left) begin
               cmd.res_load = 1'b1;
               cmd.res_oof  = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.entry_alloc = 1'b1;
               if (status.last_level) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_mapped = 1'b1;
                  state_in       = ST_DONE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // result transaction valid
   assign rsp_tvalid_in = cmd.out_load || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   // an accepted request either walks or finishes at once
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((state_ff == ST_WALK) || (state_ff == ST_DONE)))
      else $error("accepted request went nowhere");

   // a result only appears out of the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   // no allocation outside a walk of an allocate request
   a_alloc_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.entry_alloc |-> ((state_ff == ST_WALK) && status.op_alloc && status.frames_left))
      else $error("entry allocated outside an allocate walk");

endmodule

[rtl/multi_level_page_table_walker.sv]
// Radix page table walker over an on-chip frame store. A request transaction
// carries an operation (translate or allocate) and a 48-bit virtual address;
// each produces exactly one result transaction with the physical address, a
// mapped flag and an out-of-frames flag. A walk does one synchronous store
// read per level; a request that misses or runs out of frames at the root
// goes from acceptance straight to the done state, and an early miss ends the
// walk at that level. The next request is taken while the previous result
// waits in the output register. After reset the store, FRAME_COUNT *
// 2^(PAGE_OFFSET_BITS-3) entries (8192 by default), is swept to zero, one
// entry a cycle, and req_tready stays low until that sweep is done.
module multi_level_page_table_walker
   import mlptw_pkg::*;
#(
   parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF,
   parameter int LEVEL_COUNT      = LEVEL_COUNT_DEF,
   parameter int FRAME_COUNT      = FRAME_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // operation, virtual_address, zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // physical_address, mapped, out_of_frames, pad
);

   cmd_type    cmd;
   status_type status;

   // walk sequencer
   mlptw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .cmd        (cmd),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // store, allocator and address datapath
   mlptw_dp #(
      .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
      .LEVEL_COUNT      (LEVEL_COUNT),
      .FRAME_COUNT      (FRAME_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

[test/testbench.sv]
module testbench
   import mlptw_pkg::*;
();

   // walker geometry, taken from the package defaults
   localparam int POB           = PAGE_OFFSET_BITS_DEF;
   localparam int LEVELS        = LEVEL_COUNT_DEF;
   localparam int FRAMES        = FRAME_COUNT_DEF;
   localparam int IDX_W         = POB - ENTRY_IDX_SUB;
   localparam int ENTRIES       = 1 << IDX_W;
   localparam int STORE_DEPTH   = FRAMES * ENTRIES;
   localparam int FRAME_W       = $clog2(FRAMES);
   localparam int PAD_W         = REQ_TDATA_W - VA_W - 1;
   localparam int RANDOM_ITEMS  = 1150;
   localparam int DRAIN_CYCLES  = 2 * (LEVELS + 1) + 4;
   localparam int WATCHDOG_MAX  = 40000;
   localparam int MAX_REPORTS   = 10;
   localparam int POOL_MAX      = 64;
   localparam int NUM_DIRECTED  = 20;

   typedef struct packed {
      logic [PA_W-1:0] pa;
      logic            mapped;
      logic            oof;
   } walk_result_type;

   typedef struct packed {
      logic             op;
      logic [VA_W-1:0]  va;
      logic             typed;
      walk_result_type  want;
   } stim_row_type;

   localparam walk_result_type MISS_RESULT = '{pa: '0, mapped: 1'b0, oof: 1'b0};
   localparam walk_result_type OOF_RESULT  = '{pa: '0, mapped: 1'b0, oof: 1'b1};

   // directed part: fresh tree, extremes, partial install, frames exhausted
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{OP_TRANSLATE, 48'h0000_0000_0000, 1'b1, MISS_RESULT},
      '{OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 1'b1, MISS_RESULT},
      '{OP_ALLOCATE,  48'h0000_0000_0000, 1'b1, '{16'h5000, 1'b1, 1'b0}},
      '{OP_TRANSLATE, 48'h0000_0000_0FFF, 1'b0, MISS_RESULT},
      '{OP_ALLOCATE,  48'h0000_0000_0ABC, 1'b0, MISS_RESULT},
      '{OP_TRANSLATE, 48'h0000_0000_1000, 1'b0, MISS_RESULT},
      '{OP_ALLOCATE,  48'h0000_0000_1000, 1'b0, MISS_RESULT},
      '{OP_TRANSLATE, 48'h8000_0000_0000, 1'b0, MISS_RESULT},
      '{OP_ALLOCATE,  48'hFFFF_FFFF_FFFF, 1'b0, MISS_RESULT},
      '{OP_TRANSLATE, 48'hFFFF_FFFF_F123, 1'b0, MISS_RESULT},
      '{OP_ALLOCATE,  48'h0000_0020_0010, 1'b0, MISS_RESULT},
      '{OP_TRANSLATE, 48'h0000_0020_0010, 1'b0, MISS_RESULT},
      '{OP_ALLOCATE,  48'h8000_0000_0000, 1'b1, OOF_RESULT},
      '{OP_TRANSLATE, 48'h8000_0000_0000, 1'b0, MISS_RESULT},
      '{OP_ALLOCATE,  48'h8000_0000_1000, 1'b1, OOF_RESULT},
      '{OP_ALLOCATE,  48'h0000_0000_2000, 1'b1, OOF_RESULT},
      '{OP_TRANSLATE, 48'h0000_0000_2000, 1'b0, MISS_RESULT},
      '{OP_ALLOCATE,  48'h0000_0000_1FFF, 1'b0, MISS_RESULT},
      '{OP_TRANSLATE, 48'h0000_0000_0000, 1'b0, MISS_RESULT},
      '{OP_TRANSLATE, 48'h0000_0000_1FFF, 1'b0, MISS_RESULT}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // operation, virtual_address, zero pad
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // physical_address, mapped, out_of_frames, pad

   // shadow copy of the walker state
   logic [FRAME_W:0]   shadow_table [STORE_DEPTH];
   logic [FRAME_W-1:0] shadow_root;
   logic [FRAME_W:0]   shadow_bump;

   walk_result_type expected_rsp [$];
   logic [VA_W-1:0] va_pool [$];
   int              mismatch_count = 0;
   int              idle_cycles = 0;
   int              stall_left = 0;
   int              mode_left = 0;
   logic            steady = 1'b0;

   multi_level_page_table_walker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // bit position of the index used at one level, top level first
   function automatic int level_shift(input int level);
      return POB + (LEVELS - 1 - level) * IDX_W;
   endfunction

   function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va, input int level);
      int shift;
      shift = level_shift(level);
      if (shift >= VA_W) return '0;
      return IDX_W'(va >> shift);
   endfunction

   function automatic logic [PA_W-1:0] frame_address(input logic [FRAME_W-1:0] frame,
                                                     input logic [VA_W-1:0] va);
      logic [63:0] wide;
      wide = (64'(frame) << POB) | (64'(va) & ((64'd1 << POB) - 64'd1));
      return wide[PA_W-1:0];
   endfunction

   // walk the shadow tree, installing frames on an allocate
   task automatic predict_walk(input logic op, input logic [VA_W-1:0] va,
                               output walk_result_type res);
      logic [FRAME_W-1:0] frame;
      logic [FRAME_W:0]   entry;
      int                 slot;
      bit                 alive;
      res = MISS_RESULT;
      alive = 1'b1;
      if (op == OP_TRANSLATE) begin
         alive = (shadow_root != '0);
         frame = shadow_root;
         for (int level = 0; level < LEVELS; level++) begin
            if (alive) begin
               entry = shadow_table[int'(frame) * ENTRIES + int'(level_index(va, level))];
               if (!entry[0]) alive = 1'b0;
               else frame = entry[FRAME_W:1];
            end
         end
      end else begin
         // root first, then every missing table on the path
         if (shadow_root == '0) begin
            if (shadow_bump >= FRAMES) begin
               alive = 1'b0;
               res.oof = 1'b1;
            end else begin
               shadow_root = shadow_bump[FRAME_W-1:0];
               shadow_bump = shadow_bump + 1'b1;
            end
         end
         frame = shadow_root;
         for (int level = 0; level < LEVELS; level++) begin
            if (alive) begin
               slot  = int'(frame) * ENTRIES + int'(level_index(va, level));
               entry = shadow_table[slot];
               if (entry[0]) begin
                  frame = entry[FRAME_W:1];
               end else if (shadow_bump >= FRAMES) begin
                  alive = 1'b0;
                  res.oof = 1'b1;
               end else begin
                  shadow_table[slot] = {shadow_bump[FRAME_W-1:0], 1'b1};
                  frame = shadow_bump[FRAME_W-1:0];
                  shadow_bump = shadow_bump + 1'b1;
               end
            end
         end
      end
      if (alive) begin
         res.pa     = frame_address(frame, va);
         res.mapped = 1'b1;
      end
   endtask

   // mostly no gap, some short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // random address: fresh, a known path with new offset, or a path off by one level
   function automatic logic [VA_W-1:0] pick_address();
      logic [VA_W-1:0] va;
      int              kind;
      int              level;
      kind = $urandom_range(0, 9);
      if (kind < 2 || va_pool.size() == 0) begin
         va = VA_W'({$urandom(), $urandom()});
      end else begin
         va = va_pool[$urandom_range(0, va_pool.size() - 1)];
         va[POB-1:0] = POB'($urandom());
         if (kind >= 7) begin
            level = $urandom_range(0, LEVELS - 1);
            va[level_shift(level) +: IDX_W] = IDX_W'($urandom());
         end
      end
      return va;
   endfunction

   // drive one request transaction, record its expected result, then idle for a random gap outside steady stretches
   task automatic send_request(input logic op, input logic [VA_W-1:0] va,
                               input logic typed, input walk_result_type want);
      walk_result_type predicted;
      int              gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {{PAD_W{1'b0}}, va, op};
      do @(posedge clock); while (!req_tready);
      predict_walk(op, va, predicted);
      expected_rsp.push_back(typed ? want : predicted);
      if (op == OP_ALLOCATE) begin
         if (va_pool.size() >= POOL_MAX) void'(va_pool.pop_front());
         va_pool.push_back(va);
      end
      gap = steady ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // receiver back-pressure, with calm stretches of full throughput
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            steady    <= ($urandom_range(0, 3) == 0);
            mode_left <= $urandom_range(100, 400);
         end else begin
            mode_left <= mode_left - 1;
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left <= gap_len();
            rsp_tready <= 1'b1;
         end
      end
   end

   // result checker and idle-cycle counter
   always @(posedge clock) begin : rsp_monitor
      walk_result_type want;
      walk_result_type got;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{pa: rsp_tdata[PA_W-1:0], mapped: rsp_tdata[PA_W], oof: rsp_tdata[PA_W+1]};
         if (expected_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result transaction: pa %h mapped %b oof %b",
                        got.pa, got.mapped, got.oof);
         end else begin
            want = expected_rsp.pop_front();
            if (got.pa !== want.pa || got.mapped !== want.mapped || got.oof !== want.oof) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"result mismatch: expected pa %h mapped %b oof %b, ",
                            "got pa %h mapped %b oof %b"},
                           want.pa, want.mapped, want.oof, got.pa, got.mapped, got.oof);
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   initial begin
      while (idle_cycles < WATCHDOG_MAX) @(posedge clock);
      $display("multi_level_page_table_walker verification failed");
      $finish;
   end

   // main sequence
   initial begin
      logic            op;
      logic [VA_W-1:0] va;
      for (int i = 0; i < STORE_DEPTH; i++) shadow_table[i] = '0;
      shadow_root = '0;
      shadow_bump = (FRAME_W + 1)'(1);
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].va,
                      directed_rows[i].typed, directed_rows[i].want);

      // random traffic around the installed paths
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         op = $urandom_range(0, 1) ? OP_ALLOCATE : OP_TRANSLATE;
         va = pick_address();
         send_request(op, va, 1'b0, MISS_RESULT);
      end
      req_tvalid <= 1'b0;

      // drain
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0)
         $display("multi_level_page_table_walker verification clean");
      else
         $display("multi_level_page_table_walker verification failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/mlptw_pkg.sv
rtl/mlptw_ram.sv
rtl/mlptw_dp.sv
rtl/mlptw_ctrl.sv
rtl/multi_level_page_table_walker.sv
test/testbench.sv
